// ===== src/imh_pkg.sv =====
package imh_pkg;

  localparam int unsigned ValW = 32;

  localparam logic [2:0] FUNC_INSERT  = 3'd0;
  localparam logic [2:0] FUNC_READMIN = 3'd1;
  localparam logic [2:0] FUNC_DELMIN  = 3'd2;
  localparam logic [2:0] FUNC_DELID   = 3'd3;
  localparam logic [2:0] FUNC_MODIFY  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NOID  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_USE,
    S_DEL_RD,
    S_DEL_USE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_PLACE,
    S_ROOT,
    S_OUT
  } state_e;

endpackage

// ===== src/indexed_min_heap.sv =====
// Indexed binary min-heap of signed 32-bit values. Each insert gets the next insertion
// number (1 up); elements can be deleted or changed by that number. Every word in gives
// one word out: the minimum after the operation (zero when empty), the element count
// and a status. One operation at a time: each heap level walked is read, then compared
// and, if needed, moved. No clearing pass after reset.
module indexed_min_heap #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned ID_SPACE = 4096,
  localparam int unsigned SW      = $clog2(CAPACITY + 1),
  localparam int unsigned IW      = $clog2(ID_SPACE + 1),
  localparam int unsigned InDW    = ((32 + IW + 7) / 8) * 8,
  localparam int unsigned OutDW   = ((32 + SW + 2 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [InDW-1:0]  s_axis_tdata,   // item_value, insert_id, zero pad
  input  logic [2:0]       s_axis_tuser,   // func
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OutDW-1:0] m_axis_tdata    // min_value, element_count, status, zero pad
);
  import imh_pkg::*;

  localparam int unsigned EW = IW + ValW;

  state_e state_q, state_d;
  logic [2:0]      func_q, func_d;
  logic [ValW-1:0] val_q, val_d;
  logic [IW-1:0]   id_q, id_d, nid_q, nid_d;
  logic [SW-1:0]   cnt_q, cnt_d, s_q, s_d;
  logic [EW-1:0]   e_q, e_d;
  logic [1:0]      st_q, st_d;
  logic            mv_q, mv_d;
  logic [OutDW-1:0] md_q, md_d;

  logic            h_we, i_we;
  logic [SW-1:0]   h_waddr, ha_raddr, hb_raddr;
  logic [EW-1:0]   h_wdata, ha_rdata, hb_rdata;
  logic [IW-1:0]   i_waddr, i_raddr;
  logic [SW:0]     i_wdata, i_rdata;

  logic            acc;
  logic [2:0]      in_func;
  logic [ValW-1:0] in_val;
  logic [IW-1:0]   in_id;
  logic [SW:0]     lc, rc;
  logic            full, id_range, lmv, rmv, emit;
  logic [EW-1:0]   lmin;

  assign in_func  = s_axis_tuser;
  assign in_val   = s_axis_tdata[ValW-1:0];
  assign in_id    = s_axis_tdata[ValW +: IW];
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign full     = (cnt_q == SW'(CAPACITY)) || (nid_q == IW'(ID_SPACE));
  assign id_range = (in_id != '0) && (in_id <= nid_q);
  assign lc       = {s_q, 1'b0};
  assign rc       = lc + (SW+1)'(1);
  assign lmv      = $signed(ha_rdata[ValW-1:0]) < $signed(e_q[ValW-1:0]);
  assign lmin     = lmv ? ha_rdata : e_q;
  assign rmv      = (rc <= {1'b0, cnt_q}) &&
                    ($signed(hb_rdata[ValW-1:0]) < $signed(lmin[ValW-1:0]));
  assign emit     = !mv_q || m_axis_tready;

  imh_ram #(.W(EW), .AW(SW)) u_heap_a (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(ha_raddr), .rdata_o(ha_rdata)
  );

  imh_ram #(.W(EW), .AW(SW)) u_heap_b (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(hb_raddr), .rdata_o(hb_rdata)
  );

  imh_ram #(.W(SW + 1), .AW(IW)) u_index (
    .clk_i, .we_i(i_we), .waddr_i(i_waddr), .wdata_i(i_wdata),
    .raddr_i(i_raddr), .rdata_o(i_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (in_func)
            FUNC_INSERT:  state_d = full ? S_ROOT : S_UP_RD;
            FUNC_DELMIN:  state_d = (cnt_q == '0) ? S_ROOT : S_DEL_RD;
            FUNC_DELID,
            FUNC_MODIFY:  state_d = id_range ? S_LK_USE : S_ROOT;
            default:      state_d = S_ROOT;
          endcase
        end
      end
      S_LK_USE: begin
        if (!i_rdata[SW]) begin
          state_d = S_ROOT;
        end else begin
          state_d = (func_q == FUNC_MODIFY) ? S_UP_RD : S_DEL_RD;
        end
      end
      S_DEL_RD:  state_d = S_DEL_USE;
      S_DEL_USE: state_d = (s_q == cnt_q) ? S_ROOT : S_UP_RD;
      S_UP_RD:   state_d = (s_q == SW'(1)) ? S_DN_RD : S_UP_CMP;
      S_UP_CMP: begin
        if ($signed(e_q[ValW-1:0]) < $signed(ha_rdata[ValW-1:0])) begin
          state_d = S_UP_RD;
        end else begin
          state_d = S_DN_RD;
        end
      end
      S_DN_RD:  state_d = (lc > {1'b0, cnt_q}) ? S_PLACE : S_DN_CMP;
      S_DN_CMP: state_d = (rmv || lmv) ? S_DN_RD : S_PLACE;
      S_PLACE:  state_d = S_ROOT;
      S_ROOT:   state_d = S_OUT;
      S_OUT:    state_d = emit ? S_IDLE : S_OUT;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    func_d   = func_q;
    val_d    = val_q;
    id_d     = id_q;
    nid_d    = nid_q;
    cnt_d    = cnt_q;
    s_d      = s_q;
    e_d      = e_q;
    st_d     = st_q;
    md_d     = md_q;
    mv_d     = mv_q && !m_axis_tready;
    h_we     = 1'b0;
    h_waddr  = s_q;
    h_wdata  = e_q;
    ha_raddr = SW'(1);
    hb_raddr = cnt_q;
    i_we     = 1'b0;
    i_waddr  = e_q[ValW +: IW];
    i_wdata  = {1'b1, s_q};
    i_raddr  = id_q;
    s_axis_tready = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        i_raddr = in_id;
        if (acc) begin
          func_d = in_func;
          val_d  = in_val;
          id_d   = in_id;
          st_d   = ST_OK;
          s_d    = SW'(1);
          case (in_func)
            FUNC_INSERT: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                cnt_d = cnt_q + SW'(1);
                nid_d = nid_q + IW'(1);
                s_d   = cnt_q + SW'(1);
                e_d   = {nid_q + IW'(1), in_val};
              end
            end
            FUNC_READMIN,
            FUNC_DELMIN: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
              end
            end
            FUNC_DELID,
            FUNC_MODIFY: begin
              if (!id_range) begin
                st_d = ST_NOID;
              end
            end
            default: ;
          endcase
        end
      end
      S_LK_USE: begin
        if (!i_rdata[SW]) begin
          st_d = ST_NOID;
        end else begin
          s_d = i_rdata[SW-1:0];
          e_d = {id_q, val_q};
        end
      end
      S_DEL_RD: begin
        ha_raddr = s_q;
        hb_raddr = cnt_q;
      end
      S_DEL_USE: begin
        i_we    = 1'b1;
        i_waddr = ha_rdata[ValW +: IW];
        i_wdata = {1'b0, s_q};
        e_d     = hb_rdata;
        cnt_d   = cnt_q - SW'(1);
      end
      S_UP_RD: begin
        ha_raddr = s_q >> 1;
      end
      S_UP_CMP: begin
        if ($signed(e_q[ValW-1:0]) < $signed(ha_rdata[ValW-1:0])) begin
          h_we    = 1'b1;
          h_wdata = ha_rdata;
          i_we    = 1'b1;
          i_waddr = ha_rdata[ValW +: IW];
          s_d     = s_q >> 1;
        end
      end
      S_DN_RD: begin
        ha_raddr = lc[SW-1:0];
        hb_raddr = rc[SW-1:0];
      end
      S_DN_CMP: begin
        if (rmv) begin
          h_we    = 1'b1;
          h_wdata = hb_rdata;
          i_we    = 1'b1;
          i_waddr = hb_rdata[ValW +: IW];
          s_d     = rc[SW-1:0];
        end else if (lmv) begin
          h_we    = 1'b1;
          h_wdata = ha_rdata;
          i_we    = 1'b1;
          i_waddr = ha_rdata[ValW +: IW];
          s_d     = lc[SW-1:0];
        end
      end
      S_PLACE: begin
        h_we = 1'b1;
        i_we = 1'b1;
      end
      S_OUT: begin
        if (emit) begin
          mv_d = 1'b1;
          md_d = OutDW'({st_q, cnt_q, (cnt_q == '0) ? {ValW{1'b0}} : ha_rdata[ValW-1:0]});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      nid_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nid_q   <= nid_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    val_q  <= val_d;
    id_q   <= id_d;
    s_q    <= s_d;
    e_q    <= e_d;
    st_q   <= st_d;
    md_q   <= md_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;

endmodule

// ===== src/imh_ram.sv =====
module imh_ram #(
  parameter int unsigned W  = 8,
  parameter int unsigned AW = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  localparam int unsigned Depth = 1 << AW;

  logic [W-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
